>>> hw/rtl/rsrt_pkg.sv
// shared types and constants of the rtp sender statistics block
`default_nettype none
package rsrt_pkg;

   localparam int unsigned SEQ_W  = 16;
   localparam int unsigned WORD_W = 32;

   typedef enum logic [1:0] {
      CMD_SEND            = 2'd0,
      CMD_SENDER_REPORT   = 2'd1,
      CMD_RECEIVER_REPORT = 2'd2,
      CMD_CLEAR           = 2'd3
   } cmd_type;

   // one classified item as it travels from the front end to the back end
   typedef struct packed {
      cmd_type           cmd;
      logic [WORD_W-1:0] elapsed;
      logic [WORD_W-1:0] packets;
      logic [WORD_W-1:0] octets;
      logic [WORD_W-1:0] timestamp;
      logic [SEQ_W-1:0]  seq;
      logic [WORD_W-1:0] last_sr;
      logic [WORD_W-1:0] dlsr;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

>>> hw/rtl/rsrt_front.sv
// front end: accepts beats, keeps sender counters and takes snapshots
`default_nettype none
module rsrt_front import rsrt_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cmd_type           req_cmd,
   input  wire logic [WORD_W-1:0] req_now_ticks,
   input  wire logic [SEQ_W-1:0]  req_payload_len,
   input  wire logic [WORD_W-1:0] req_rtp_timestamp,
   input  wire logic              req_set_seq,
   input  wire logic [SEQ_W-1:0]  req_seq_value,
   input  wire logic [WORD_W-1:0] req_last_sr,
   input  wire logic [WORD_W-1:0] req_delay_since_sr,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [WORD_W-1:0] csr_data,
   input  wire queue_status_type  queue_status,
   output logic                   push,
   output job_type                push_job,
   output logic [WORD_W-1:0]      epoch_sec
);

   localparam logic CSR_BASE_SEQ  = 1'b0;
   localparam logic CSR_NTP_EPOCH = 1'b1;

   logic [SEQ_W-1:0]  base_seq_ff,    base_seq_in;
   logic [WORD_W-1:0] epoch_ff,       epoch_in;
   logic [SEQ_W-1:0]  next_seq_ff,    next_seq_in;
   logic [SEQ_W-1:0]  wrap_count_ff,  wrap_count_in;
   logic [WORD_W-1:0] octet_total_ff, octet_total_in;
   logic [WORD_W-1:0] last_ts_ff,     last_ts_in;
   logic              synced_ff,      synced_in;
   logic [WORD_W-1:0] sync_ticks_ff,  sync_ticks_in;

   logic [SEQ_W-1:0] seq_pick;
   logic [SEQ_W-1:0] seq_inc;

   assign req_ready = !queue_status.full;
   assign push      = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign epoch_sec = epoch_ff;

   always_comb begin
      seq_pick = req_set_seq ? req_seq_value : next_seq_ff;
      seq_inc  = seq_pick + SEQ_W'(1);

      push_job.cmd       = req_cmd;
      push_job.elapsed   = req_now_ticks - sync_ticks_ff;
      push_job.packets   = {wrap_count_ff, next_seq_ff} - WORD_W'(base_seq_ff);
      push_job.octets    = octet_total_ff;
      push_job.timestamp = last_ts_ff;
      push_job.seq       = seq_pick;
      push_job.last_sr   = req_last_sr;
      push_job.dlsr      = req_delay_since_sr;
   end

   always_comb begin
      base_seq_in    = base_seq_ff;
      epoch_in       = epoch_ff;
      next_seq_in    = next_seq_ff;
      wrap_count_in  = wrap_count_ff;
      octet_total_in = octet_total_ff;
      last_ts_in     = last_ts_ff;
      synced_in      = synced_ff;
      sync_ticks_in  = sync_ticks_ff;
      if (push) begin
         case (req_cmd)
            CMD_SEND: begin
               if (!synced_ff) begin
                  synced_in     = 1'b1;
                  sync_ticks_in = req_now_ticks;
               end
               octet_total_in = octet_total_ff + WORD_W'(req_payload_len);
               last_ts_in     = req_rtp_timestamp;
               next_seq_in    = seq_inc;
               if (seq_inc == '0) begin
                  wrap_count_in = wrap_count_ff + SEQ_W'(1);
               end
            end
            CMD_CLEAR: begin
               wrap_count_in  = '0;
               octet_total_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_SEQ: begin
               base_seq_in = csr_data[SEQ_W-1:0];
               next_seq_in = csr_data[SEQ_W-1:0];
            end
            CSR_NTP_EPOCH: begin
               epoch_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_seq_ff    <= '0;
         epoch_ff       <= '0;
         next_seq_ff    <= '0;
         wrap_count_ff  <= '0;
         octet_total_ff <= '0;
         last_ts_ff     <= '0;
         synced_ff      <= 1'b0;
         sync_ticks_ff  <= '0;
      end else begin
         base_seq_ff    <= base_seq_in;
         epoch_ff       <= epoch_in;
         next_seq_ff    <= next_seq_in;
         wrap_count_ff  <= wrap_count_in;
         octet_total_ff <= octet_total_in;
         last_ts_ff     <= last_ts_in;
         synced_ff      <= synced_in;
         sync_ticks_ff  <= sync_ticks_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/rsrt_queue.sv
// short job queue between front end and back end
`default_nettype none
module rsrt_queue import rsrt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output queue_status_type status
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff,  count_in;

   assign head_job     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/rsrt_back.sv
// back end: ntp time, fraction and round trip pipeline with output register
`default_nettype none
module rsrt_back import rsrt_pkg::*; #(
   parameter int unsigned TICKS_PER_SEC = 10000
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [WORD_W-1:0] epoch_sec,
   input  wire job_type           head_job,
   input  wire queue_status_type  queue_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [SEQ_W-1:0]       rsp_seq_used,
   output logic [WORD_W-1:0]      rsp_packets_sent,
   output logic [WORD_W-1:0]      rsp_octets_sent,
   output logic [WORD_W-1:0]      rsp_ntp_seconds,
   output logic [WORD_W-1:0]      rsp_ntp_fraction,
   output logic [WORD_W-1:0]      rsp_last_timestamp,
   output logic [WORD_W-1:0]      rsp_round_trip
);

   localparam int unsigned TW     = $clog2(TICKS_PER_SEC + 1);
   localparam int unsigned R48_W  = 49 - $clog2(TICKS_PER_SEC);
   localparam int unsigned LO_W   = 19;
   localparam int unsigned HI_W   = R48_W - LO_W;
   localparam int unsigned SUM_W  = TW + R48_W + 1;
   localparam int unsigned FP_W   = SEQ_W + TW;
   localparam int unsigned CMP_W  = TW + 17;
   localparam int unsigned VW     = TW + 17;
   localparam int unsigned STAGES = 9;

   localparam logic [TW-1:0]     TICK  = TW'(TICKS_PER_SEC);
   localparam logic [WORD_W-1:0] RECIP = WORD_W'((64'd1 << 32) / TICKS_PER_SEC);
   localparam logic [R48_W-1:0]  R48   = R48_W'((64'd1 << 48) / TICKS_PER_SEC);
   localparam logic [HI_W-1:0]   R48_HI = R48[R48_W-1:LO_W];
   localparam logic [LO_W-1:0]   R48_LO = R48[LO_W-1:0];

   typedef struct packed {
      job_type             job;
      logic [WORD_W-1:0]   quo;
      logic [WORD_W-1:0]   prod;
      logic [TW-1:0]       rem;
      logic [WORD_W-1:0]   seconds;
      logic [TW+HI_W-1:0]  part_hi;
      logic [TW+LO_W-1:0]  part_lo;
      logic [SEQ_W-1:0]    frac;
      logic [FP_W-1:0]     frac_prod;
      logic [WORD_W-1:0]   diff;
      logic                rtt_ok;
      logic [FP_W-1:0]     rtt_hi;
      logic [FP_W-1:0]     rtt_lo;
   } work_type;

   work_type w_ff [STAGES];
   work_type w_in [STAGES];
   logic [STAGES-1:0] vld_ff;

   logic advance;
   logic out_valid_ff;
   logic [SEQ_W-1:0]  seq_ff,  seq_in;
   logic [WORD_W-1:0] pk_ff,   pk_in;
   logic [WORD_W-1:0] oct_ff,  oct_in;
   logic [WORD_W-1:0] sec_ff,  sec_in;
   logic [WORD_W-1:0] frac_ff, frac_in;
   logic [WORD_W-1:0] ts_ff,   ts_in;
   logic [WORD_W-1:0] rtt_ff,  rtt_in;

   logic [2*WORD_W-1:0] recip_prod;
   logic [WORD_W+TW-1:0] quo_prod;
   logic [WORD_W-1:0]   rem_raw;
   logic [SUM_W-1:0]    frac_sum;
   logic [CMP_W-1:0]    frac_left;
   logic [CMP_W-1:0]    frac_limit;
   logic [WORD_W-1:0]   ntp_now;
   logic [VW-1:0]       rtt_sum;

   // the whole pipe moves whenever the output register can take a beat
   assign advance   = !out_valid_ff || rsp_ready;
   assign pop       = advance && !queue_status.empty;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      // stage 0: quotient estimate by reciprocal
      recip_prod  = 64'(head_job.elapsed) * 64'(RECIP);
      w_in[0]     = '0;
      w_in[0].job = head_job;
      w_in[0].quo = recip_prod[2*WORD_W-1:WORD_W];

      // stage 1: estimate times tick rate
      w_in[1]      = w_ff[0];
      quo_prod     = (WORD_W+TW)'(w_ff[0].quo) * (WORD_W+TW)'(TICK);
      w_in[1].prod = quo_prod[WORD_W-1:0];

      // stage 2: one correction step
      w_in[2] = w_ff[1];
      rem_raw = w_ff[1].job.elapsed - w_ff[1].prod;
      if (rem_raw >= WORD_W'(TICK)) begin
         w_in[2].quo = w_ff[1].quo + WORD_W'(1);
         w_in[2].rem = TW'(rem_raw - WORD_W'(TICK));
      end else begin
         w_in[2].rem = TW'(rem_raw);
      end

      // stage 3: seconds, and fraction partial products
      w_in[3]         = w_ff[2];
      w_in[3].seconds = epoch_sec + w_ff[2].quo;
      w_in[3].part_hi = (TW+HI_W)'(w_ff[2].rem) * (TW+HI_W)'(R48_HI);
      w_in[3].part_lo = (TW+LO_W)'(w_ff[2].rem) * (TW+LO_W)'(R48_LO);

      // stage 4: fraction estimate
      w_in[4]      = w_ff[3];
      frac_sum     = (SUM_W'(w_ff[3].part_hi) << LO_W) + SUM_W'(w_ff[3].part_lo);
      w_in[4].frac = frac_sum[47:32];

      // stage 5: estimate times tick rate
      w_in[5]           = w_ff[4];
      w_in[5].frac_prod = FP_W'(w_ff[4].frac) * FP_W'(TICK);

      // stage 6: fraction correction
      w_in[6]    = w_ff[5];
      frac_left  = CMP_W'({w_ff[5].rem, 16'h0000});
      frac_limit = CMP_W'(w_ff[5].frac_prod) + CMP_W'(TICK);
      if (frac_left >= frac_limit) begin
         w_in[6].frac = w_ff[5].frac + SEQ_W'(1);
      end

      // stage 7: ntp 16.16 minus lsr and dlsr
      w_in[7]        = w_ff[6];
      ntp_now        = {w_ff[6].seconds[15:0], w_ff[6].frac};
      w_in[7].diff   = ntp_now - w_ff[6].job.last_sr - w_ff[6].job.dlsr;
      w_in[7].rtt_ok = (w_ff[6].job.last_sr != '0) && (w_in[7].diff != '0)
                       && !w_in[7].diff[WORD_W-1];

      // stage 8: whole and fractional seconds in ticks
      w_in[8]        = w_ff[7];
      w_in[8].rtt_hi = FP_W'(w_ff[7].diff[31:16]) * FP_W'(TICK);
      w_in[8].rtt_lo = FP_W'(w_ff[7].diff[15:0]) * FP_W'(TICK);
   end

   always_comb begin
      rtt_sum = VW'(w_ff[8].rtt_hi) + VW'(w_ff[8].rtt_lo >> 16);
      seq_in  = '0;
      pk_in   = '0;
      oct_in  = '0;
      sec_in  = '0;
      frac_in = '0;
      ts_in   = '0;
      rtt_in  = '0;
      case (w_ff[8].job.cmd)
         CMD_SEND: begin
            seq_in = w_ff[8].job.seq;
         end
         CMD_SENDER_REPORT: begin
            pk_in   = w_ff[8].job.packets;
            oct_in  = w_ff[8].job.octets;
            sec_in  = w_ff[8].seconds;
            frac_in = {w_ff[8].frac, 16'h0000};
            ts_in   = w_ff[8].job.timestamp;
         end
         CMD_RECEIVER_REPORT: begin
            if (w_ff[8].rtt_ok) begin
               if ((VW > WORD_W) && (rtt_sum > VW'(32'hFFFF_FFFF))) begin
                  rtt_in = '1;
               end else begin
                  rtt_in = WORD_W'(rtt_sum);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < STAGES; i++) begin
            w_ff[i] <= w_in[i];
         end
         seq_ff  <= seq_in;
         pk_ff   <= pk_in;
         oct_ff  <= oct_in;
         sec_ff  <= sec_in;
         frac_ff <= frac_in;
         ts_ff   <= ts_in;
         rtt_ff  <= rtt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[STAGES-2:0], !queue_status.empty};
         out_valid_ff <= vld_ff[STAGES-1];
      end
   end

   assign rsp_seq_used       = seq_ff;
   assign rsp_packets_sent   = pk_ff;
   assign rsp_octets_sent    = oct_ff;
   assign rsp_ntp_seconds    = sec_ff;
   assign rsp_ntp_fraction   = frac_ff;
   assign rsp_last_timestamp = ts_ff;
   assign rsp_round_trip     = rtt_ff;

endmodule
`default_nettype wire

>>> hw/rtl/rtp_sender_stats_and_rtt_top.sv
// top level of the rtp sender statistics and round trip block
//
// req channel: one beat per command (tuser holds the command). a packet sent
// beat advances the sequence number and the octet and wrap counters; a sender
// report beat snapshots the counters and elapsed ticks; a receiver report beat
// carries lsr and dlsr; a clear beat zeroes the wrap and octet counters.
// rsp channel: exactly one result beat per request beat, in order; fields
// that do not belong to the command read as zero.
// csr channel: index 0 base sequence number (also reloads the next sequence
// number), index 1 ntp seconds at the first sent packet; always ready.
// a request beat is written into the queue and then passes the nine stage
// arithmetic pipe and the output register of the back end, so one beat per
// cycle is sustained while the receiver is ready.
// a four entry queue sits between the counter front end and the pipe: when
// the receiver stalls, the pipe and output hold, the queue fills, and only
// then does req_tready drop.
// reset (synchronous) clears counters, registers, queue and pipe valid bits.
`default_nettype none
module rtp_sender_stats_and_rtt_top import rsrt_pkg::*; #(
   parameter int unsigned TICKS_PER_SEC = 10000
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // now_ticks[31:0] payload_len[47:32] rtp_timestamp[79:48] set_seq[80]
   // seq_value[96:81] last_sr[128:97] delay_since_sr[160:129] zero pad[167:161]
   input  wire logic [167:0] req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // seq_used[15:0] packets_sent[47:16] octets_sent[79:48] ntp_seconds[111:80]
   // ntp_fraction[143:112] last_timestamp[175:144] round_trip[207:176]
   output logic [207:0]      rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [31:0]  csr_data
);

   job_type          push_job;
   job_type          head_job;
   queue_status_type queue_status;
   logic             push;
   logic             pop;
   logic [WORD_W-1:0] epoch_sec;

   logic [SEQ_W-1:0]  seq_used;
   logic [WORD_W-1:0] packets_sent;
   logic [WORD_W-1:0] octets_sent;
   logic [WORD_W-1:0] ntp_seconds;
   logic [WORD_W-1:0] ntp_fraction;
   logic [WORD_W-1:0] last_timestamp;
   logic [WORD_W-1:0] round_trip;

   // counters and snapshots, one beat per cycle while the queue has room
   rsrt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_tvalid),
      .req_ready          (req_tready),
      .req_cmd            (cmd_type'(req_tuser)),
      .req_now_ticks      (req_tdata[31:0]),
      .req_payload_len    (req_tdata[47:32]),
      .req_rtp_timestamp  (req_tdata[79:48]),
      .req_set_seq        (req_tdata[80]),
      .req_seq_value      (req_tdata[96:81]),
      .req_last_sr        (req_tdata[128:97]),
      .req_delay_since_sr (req_tdata[160:129]),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .queue_status       (queue_status),
      .push               (push),
      .push_job           (push_job),
      .epoch_sec          (epoch_sec)
   );

   // decouples the counter side from a stalled receiver
   rsrt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   // constant division by reciprocal, fraction and round trip
   rsrt_back #(
      .TICKS_PER_SEC (TICKS_PER_SEC)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .epoch_sec          (epoch_sec),
      .head_job           (head_job),
      .queue_status       (queue_status),
      .pop                (pop),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_seq_used       (seq_used),
      .rsp_packets_sent   (packets_sent),
      .rsp_octets_sent    (octets_sent),
      .rsp_ntp_seconds    (ntp_seconds),
      .rsp_ntp_fraction   (ntp_fraction),
      .rsp_last_timestamp (last_timestamp),
      .rsp_round_trip     (round_trip)
   );

   assign rsp_tdata = {round_trip, last_timestamp, ntp_fraction, ntp_seconds,
                       octets_sent, packets_sent, seq_used};

endmodule
`default_nettype wire

>>> hw/rtl/rsrt_checker.sv
// port level checks for the rtp sender statistics block, with its bind
`default_nettype none
module rsrt_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [207:0] rsp_tdata
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // a sent packet beat carries nothing but its sequence number
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:0] != 16'h0000) |-> (rsp_tdata[207:16] == '0))
      else $error("sequence result with other fields set");

   // a round trip beat carries nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[207:176] != 32'h0) |-> (rsp_tdata[175:0] == '0))
      else $error("round trip result with other fields set");

   // the ntp fraction only ever has its upper half set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[127:112] == 16'h0000))
      else $error("ntp fraction low half not zero");

endmodule

bind rtp_sender_stats_and_rtt_top rsrt_checker u_checker (.*);
`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench for the rtp sender statistics and round trip block
`default_nettype none
module tb_top;
   import rsrt_pkg::*;

   localparam int unsigned STATS_TICKS = 10000;
   localparam int unsigned PHASE_ITEMS = 317;
   localparam int unsigned DRAIN_CYCLES = 16;

   // csr register indexes
   localparam logic REG_BASE_SEQ  = 1'b0;
   localparam logic REG_NTP_EPOCH = 1'b1;

   // request payload as it sits on req_tdata, lowest field in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic [31:0] delay_since_sr;
      logic [31:0] last_sr;
      logic [15:0] seq_value;
      logic        set_seq;
      logic [31:0] rtp_timestamp;
      logic [15:0] payload_len;
      logic [31:0] now_ticks;
   } req_payload_type;

   // result beat as it sits on rsp_tdata
   typedef struct packed {
      logic [31:0] round_trip;
      logic [31:0] last_timestamp;
      logic [31:0] ntp_fraction;
      logic [31:0] ntp_seconds;
      logic [31:0] octets_sent;
      logic [31:0] packets_sent;
      logic [15:0] seq_used;
   } stats_report_type;

   typedef struct {
      cmd_type         cmd;
      req_payload_type data;
      int unsigned     gap;
   } pending_cmd_type;

   typedef struct {
      logic [31:0] sec;
      logic [15:0] frac;
   } ntp_time_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic         csr_index  = 1'b0;
   logic [31:0]  csr_data   = '0;

   rtp_sender_stats_and_rtt_top #(
      .TICKS_PER_SEC(STATS_TICKS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // shadow copy of the block's counters and registers
   // ---------------------------------------------------------------------
   logic [15:0] seq_base   = '0;
   logic [31:0] epoch_sec  = '0;
   logic [15:0] seq_next   = '0;
   logic [15:0] seq_wraps  = '0;
   logic [31:0] octet_sum  = '0;
   logic [31:0] ts_last    = '0;
   logic        sync_done  = 1'b0;
   logic [31:0] sync_tick  = '0;

   // ntp time reached at a given tick count, split into seconds and 16 bit fraction
   function automatic ntp_time_type ntp_at(input logic [31:0] now, input logic [31:0] sync,
                                           input logic [31:0] epoch);
      logic [31:0]  el;
      logic [63:0]  rem;
      ntp_time_type t;
      el     = now - sync;
      t.sec  = epoch + el / STATS_TICKS;
      rem    = 64'(el % STATS_TICKS);
      t.frac = 16'((rem << 16) / STATS_TICKS);
      return t;
   endfunction

   // apply one command to the shadow counters and return the result it yields
   function automatic stats_report_type advance_stats(input cmd_type cmd,
                                                      input req_payload_type d);
      stats_report_type r;
      ntp_time_type     t;
      logic [31:0]      diff;
      logic [63:0]      ticks;
      r = '0;
      // elapsed is taken against the sync point, which is still 0 before any packet
      t = ntp_at(d.now_ticks, sync_tick, epoch_sec);
      case (cmd)
         CMD_SEND: begin
            if (!sync_done) begin
               sync_done = 1'b1;
               sync_tick = d.now_ticks;
            end
            if (d.set_seq)
               seq_next = d.seq_value;
            r.seq_used = seq_next;
            octet_sum  = octet_sum + 32'(d.payload_len);
            ts_last    = d.rtp_timestamp;
            seq_next   = seq_next + 16'd1;
            // sequence wrap bumps the wrap counter, which wraps itself at 16 bits
            if (seq_next == 16'd0)
               seq_wraps = seq_wraps + 16'd1;
         end
         CMD_SENDER_REPORT: begin
            r.packets_sent   = 32'(seq_next) + {seq_wraps, 16'h0000} - 32'(seq_base);
            r.octets_sent    = octet_sum;
            r.ntp_seconds    = t.sec;
            r.ntp_fraction   = {t.frac, 16'h0000};
            r.last_timestamp = ts_last;
         end
         CMD_RECEIVER_REPORT: begin
            // difference read as signed; zero lsr or non-positive delay gives 0
            diff = {t.sec[15:0], t.frac} - d.last_sr - d.delay_since_sr;
            if (d.last_sr != '0 && diff != '0 && !diff[31]) begin
               ticks = 64'(diff[31:16]) * STATS_TICKS
                     + ((64'(diff[15:0]) * STATS_TICKS) >> 16);
               r.round_trip = (ticks > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ticks[31:0];
            end
         end
         default: begin
            // clear keeps the next sequence number, last timestamp and sync point
            seq_wraps = '0;
            octet_sum = '0;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // request driver: pops the pending queue, changes inputs on the falling edge
   // ---------------------------------------------------------------------
   pending_cmd_type  pending_cmds[$];
   pending_cmd_type  on_wire;
   stats_report_type stats_due[$];
   logic             req_took = 1'b0;
   int unsigned      req_wait = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_cmds.size() != 0 && req_wait >= pending_cmds[0].gap) begin
            on_wire = pending_cmds.pop_front();
            req_tuser  <= on_wire.cmd;
            req_tdata  <= on_wire.data;
            req_tvalid <= 1'b1;
            req_wait = 0;
         end else begin
            // sender idles for the gap drawn with the next beat
            req_tvalid <= 1'b0;
            if (pending_cmds.size() != 0)
               req_wait++;
         end
      end
   end

   // receiver: stall length drawn after every result beat
   int unsigned rsp_hold   = 0;
   logic        rsp_steady = 1'b0;

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: records accepted requests and checks result beats at the rising edge
   // ---------------------------------------------------------------------
   int unsigned      mismatches      = 0;
   int unsigned      results_checked = 0;
   int unsigned      rsp_taken       = 0;
   int unsigned      cmd_seen [4]    = '{0, 0, 0, 0};
   stats_report_type want;
   stats_report_type got;

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s of result %0d: expected %h, got %h",
                     name, results_checked, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      req_took = !reset && req_tvalid && req_tready;
      if (req_took) begin
         stats_due.push_back(advance_stats(on_wire.cmd, on_wire.data));
         cmd_seen[on_wire.cmd]++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (stats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result beat with nothing expected: %h", rsp_tdata);
         end else begin
            want = stats_due.pop_front();
            check_field("seq_used", 32'(want.seq_used), 32'(got.seq_used));
            check_field("packets_sent", want.packets_sent, got.packets_sent);
            check_field("octets_sent", want.octets_sent, got.octets_sent);
            check_field("ntp_seconds", want.ntp_seconds, got.ntp_seconds);
            check_field("ntp_fraction", want.ntp_fraction, got.ntp_fraction);
            check_field("last_timestamp", want.last_timestamp, got.last_timestamp);
            check_field("round_trip", want.round_trip, got.round_trip);
            results_checked++;
         end
         // stretches without stalls now and then
         rsp_taken++;
         if (rsp_taken % 40 == 0)
            rsp_steady = ($urandom_range(0, 2) == 0);
         rsp_hold = rsp_steady ? 0 : $urandom_range(0, 10);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   // generator side view of the sync point, needed to aim lsr at the current ntp time
   logic        gen_synced = 1'b0;
   logic [31:0] gen_sync   = '0;
   logic [31:0] gen_epoch  = '0;
   logic [31:0] gen_now    = '0;
   logic        gen_steady = 1'b0;
   int unsigned gen_count  = 0;
   int unsigned settings   = 1;

   task automatic queue_cmd(input cmd_type c, input req_payload_type d);
      pending_cmd_type it;
      if (gen_count % 40 == 0)
         gen_steady = ($urandom_range(0, 2) == 0);
      gen_count++;
      it.cmd  = c;
      it.data = d;
      it.gap  = gen_steady ? 0 : $urandom_range(0, 10);
      if (c == CMD_SEND && !gen_synced) begin
         gen_synced = 1'b1;
         gen_sync   = d.now_ticks;
      end
      pending_cmds.push_back(it);
   endtask

   function automatic req_payload_type rand_payload();
      req_payload_type d;
      d.pad            = '0;
      d.now_ticks      = $urandom;
      d.payload_len    = 16'($urandom);
      d.rtp_timestamp  = $urandom;
      d.set_seq        = 1'($urandom);
      d.seq_value      = 16'($urandom);
      d.last_sr        = $urandom;
      d.delay_since_sr = $urandom;
      return d;
   endfunction

   // lsr that leaves the given difference against the ntp time at this tick count
   function automatic logic [31:0] lsr_for(input req_payload_type d, input logic [31:0] diff);
      ntp_time_type t;
      t = ntp_at(d.now_ticks, gen_sync, gen_epoch);
      return {t.sec[15:0], t.frac} - d.delay_since_sr - diff;
   endfunction

   // csr writes happen only with the block idle; the shadow registers follow at the beat
   task automatic write_register(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_BASE_SEQ) begin
         seq_base = value[15:0];
         seq_next = value[15:0];
      end else begin
         epoch_sec = value;
         gen_epoch = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every queued command to go out and every result to return
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || stats_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      req_payload_type d;
      cmd_type         c;
      ntp_time_type    t;
      logic [31:0]     delta;
      logic [31:0]     phase_base [6];
      logic [31:0]     phase_epoch [6];
      int unsigned     pick;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, registers at their reset values
      // sender report before any packet: elapsed is the raw tick count
      d = rand_payload(); d.now_ticks = 32'hFFFF_FFFF;
      queue_cmd(CMD_SENDER_REPORT, d);
      d = rand_payload(); d.last_sr = '0; d.delay_since_sr = 32'hFFFF_FFFF;
      queue_cmd(CMD_RECEIVER_REPORT, d);
      d = rand_payload(); d.now_ticks = 32'd123456; d.delay_since_sr = 32'h0002_0000;
      d.last_sr = lsr_for(d, 32'h0001_0000);
      queue_cmd(CMD_RECEIVER_REPORT, d);
      // first packet fixes the sync point; forced sequence walks through the wrap
      d = '0; d.now_ticks = 32'd5000; d.payload_len = 16'hFFFF;
      d.rtp_timestamp = 32'hFFFF_FFFF; d.set_seq = 1'b1; d.seq_value = 16'hFFFE;
      queue_cmd(CMD_SEND, d);
      d = '0; d.now_ticks = 32'd5001;
      queue_cmd(CMD_SEND, d);
      d = rand_payload(); d.now_ticks = 32'd6000; d.set_seq = 1'b0; d.payload_len = 16'd1;
      queue_cmd(CMD_SEND, d);
      d = rand_payload(); d.now_ticks = 32'd5000;
      queue_cmd(CMD_SENDER_REPORT, d);
      // tick count below the sync point: elapsed wraps
      d = rand_payload(); d.now_ticks = 32'd4999;
      queue_cmd(CMD_SENDER_REPORT, d);
      // round trip right at and around the sign boundary of the difference
      d = rand_payload(); d.now_ticks = 32'd987654; d.delay_since_sr = 32'h0001_0000;
      d.last_sr = lsr_for(d, 32'h0000_0000);
      queue_cmd(CMD_RECEIVER_REPORT, d);
      d.last_sr = lsr_for(d, 32'hFFFF_FFFF);
      queue_cmd(CMD_RECEIVER_REPORT, d);
      d.last_sr = lsr_for(d, 32'h0000_0001);
      queue_cmd(CMD_RECEIVER_REPORT, d);
      d.last_sr = lsr_for(d, 32'h7FFF_FFFF);
      queue_cmd(CMD_RECEIVER_REPORT, d);
      d.last_sr = lsr_for(d, 32'h8000_0000);
      queue_cmd(CMD_RECEIVER_REPORT, d);
      d = '1; d.pad = '0;
      queue_cmd(CMD_CLEAR, d);
      d = rand_payload(); d.now_ticks = 32'd0;
      queue_cmd(CMD_SENDER_REPORT, d);
      d = '1; d.pad = '0; d.seq_value = '0;
      queue_cmd(CMD_SEND, d);
      d = rand_payload(); d.set_seq = 1'b0; d.seq_value = 16'hFFFF;
      queue_cmd(CMD_SEND, d);
      d = rand_payload(); d.now_ticks = 32'hFFFF_FFFF;
      queue_cmd(CMD_SENDER_REPORT, d);
      gen_now = 32'd10000;
      wait_drained();

      // register settings per random phase, extreme values mixed with random ones
      phase_base  = '{32'h0000_FFFF, 32'h0000_0000, $urandom, 32'h0000_FFF0,
                      32'hFFFF_0001, $urandom};
      phase_epoch = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h8000_0000,
                      32'h7FFF_FFFF, $urandom};

      for (int ph = 0; ph < 6; ph++) begin
         write_register(REG_BASE_SEQ, phase_base[ph]);
         write_register(REG_NTP_EPOCH, phase_epoch[ph]);
         settings++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            d = rand_payload();
            // time mostly runs forward, with the odd jump anywhere in the range
            gen_now = gen_now + (($urandom_range(0, 19) == 0) ? $urandom
                                                              : $urandom_range(0, 30000));
            d.now_ticks = gen_now;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               c = CMD_SEND;
               d.set_seq = ($urandom_range(0, 15) == 0);
               if ($urandom_range(0, 1) == 1)
                  d.seq_value = 16'hFFFF - 16'($urandom_range(0, 8));
            end else if (pick < 70) begin
               c = CMD_SENDER_REPORT;
            end else if (pick < 94) begin
               c = CMD_RECEIVER_REPORT;
               if ($urandom_range(0, 1) == 1)
                  d.delay_since_sr = $urandom_range(0, 32'h0005_0000);
               pick = $urandom_range(0, 9);
               if (pick == 0) begin
                  d.last_sr = '0;
               end else if (pick >= 3) begin
                  // aim lsr so the delay lands near zero, moderate or anywhere
                  if (pick < 5)
                     delta = $urandom_range(0, 6) - 3;
                  else if (pick < 8)
                     delta = $urandom_range(1, 32'h0010_0000);
                  else
                     delta = $urandom;
                  t = ntp_at(d.now_ticks, gen_sync, gen_epoch);
                  d.last_sr = {t.sec[15:0], t.frac} - d.delay_since_sr - delta;
               end
            end else begin
               c = CMD_CLEAR;
            end
            queue_cmd(c, d);
         end
         wait_drained();
      end

      mismatches = mismatches + stats_due.size();
      $display("checked %0d results from %0d sends, %0d sender reports, %0d receiver reports",
               results_checked, cmd_seen[CMD_SEND], cmd_seen[CMD_SENDER_REPORT],
               cmd_seen[CMD_RECEIVER_REPORT]);
      $display("and %0d clears over %0d register settings, %0d mismatches",
               cmd_seen[CMD_CLEAR], settings, mismatches);
      if (mismatches == 0)
         $display("rtp_sender_stats_and_rtt_top verification clean");
      else
         $display("rtp_sender_stats_and_rtt_top verification failed");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #(64'd8 * 64'd600000);
      $display("timeout with %0d results outstanding", stats_due.size());
      $display("rtp_sender_stats_and_rtt_top verification failed");
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/rsrt_pkg.sv
hw/rtl/rsrt_front.sv
hw/rtl/rsrt_queue.sv
hw/rtl/rsrt_back.sv
hw/rtl/rtp_sender_stats_and_rtt_top.sv
hw/rtl/rsrt_checker.sv
test/tb_top.sv
